// ----- hdl/rps_pkg.sv -----
// Shared types and constants for the rhythm pattern sequencer.
// No dependencies; used by the interfaces, controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none
package rps_pkg;
  localparam int MAX_STEPS = 32;
  localparam int IDX_W     = 5;   // step index into the 32-entry pattern
  localparam int CNT_W     = 6;   // counts 0..32
  localparam int WORD_W    = 33;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 6;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAD    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HITS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACCENT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ASHIFT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STYLE  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BACK   = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_SEQ, ST_SRC_INIT, ST_SRC, ST_PLACE_INIT, ST_PLACE,
    ST_STEP, ST_MOD, ST_SHIFT, ST_FINISH
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_CLEAR, CMD_SEQ, CMD_SRC_INIT, CMD_SRC,
    CMD_PLACE_INIT, CMD_PLACE, CMD_STEP, CMD_MOD, CMD_SHIFT, CMD_FINISH
  } cmd_t;

  typedef struct packed {
    logic pending;
    logic out_busy;
    logic tick_clk;
    logic seq_done;
    logic src_done;
    logic place_done;
    logic mod_done;
    logic shift_done;
  } status_t;
endpackage
`default_nettype wire

// ----- hdl/rps_if.sv -----
// Handshake interfaces for the input, result and configuration channels.
// Depends on rps_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none
interface rps_in_if;
  logic valid;
  logic ready;
  logic clock_edge;
  logic reset_edge;
  modport source (output valid, clock_edge, reset_edge, input ready);
  modport sink (input valid, clock_edge, reset_edge, output ready);
endinterface

interface rps_out_if;
  logic valid;
  logic ready;
  logic gate_hit;
  logic accent_hit;
  logic end_of_cycle;
  logic [rps_pkg::CNT_W-1:0] step_index;
  logic [rps_pkg::WORD_W-1:0] shift_word;
  modport source (output valid, gate_hit, accent_hit, end_of_cycle, step_index, shift_word,
                  input ready);
  modport sink (input valid, gate_hit, accent_hit, end_of_cycle, step_index, shift_word,
                output ready);
endinterface

interface rps_cfg_if;
  logic valid;
  logic ready;
  logic [rps_pkg::CFG_IDX_W-1:0] index;
  logic [rps_pkg::CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hdl/rps_ctrl.sv -----
// Controller state machine: sequences pattern rebuild and tick processing.
// Depends on rps_pkg; drives commands into rps_dp.
`timescale 1ns / 1ps
`default_nettype none
module rps_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire rps_pkg::status_t  status,
  output rps_pkg::cmd_t          cmd
);
  rps_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= rps_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = rps_pkg::CMD_NONE;
    in_ready   = 1'b0;
    case (state)
      rps_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd        = rps_pkg::CMD_LOAD;
          state_next = status.pending ? rps_pkg::ST_CLEAR : rps_pkg::ST_STEP;
        end
      end
      rps_pkg::ST_CLEAR: begin
        cmd        = rps_pkg::CMD_CLEAR;
        state_next = rps_pkg::ST_SEQ;
      end
      rps_pkg::ST_SEQ: begin
        cmd = rps_pkg::CMD_SEQ;
        if (status.seq_done) state_next = rps_pkg::ST_SRC_INIT;
      end
      rps_pkg::ST_SRC_INIT: begin
        cmd        = rps_pkg::CMD_SRC_INIT;
        state_next = rps_pkg::ST_SRC;
      end
      rps_pkg::ST_SRC: begin
        cmd = rps_pkg::CMD_SRC;
        if (status.src_done) state_next = rps_pkg::ST_PLACE_INIT;
      end
      rps_pkg::ST_PLACE_INIT: begin
        cmd        = rps_pkg::CMD_PLACE_INIT;
        state_next = rps_pkg::ST_PLACE;
      end
      rps_pkg::ST_PLACE: begin
        cmd = rps_pkg::CMD_PLACE;
        if (status.place_done) state_next = rps_pkg::ST_STEP;
      end
      rps_pkg::ST_STEP: begin
        cmd        = rps_pkg::CMD_STEP;
        state_next = status.tick_clk ? rps_pkg::ST_MOD : rps_pkg::ST_FINISH;
      end
      rps_pkg::ST_MOD: begin
        cmd = rps_pkg::CMD_MOD;
        if (status.mod_done) state_next = rps_pkg::ST_SHIFT;
      end
      rps_pkg::ST_SHIFT: begin
        cmd = rps_pkg::CMD_SHIFT;
        if (status.shift_done) state_next = rps_pkg::ST_FINISH;
      end
      rps_pkg::ST_FINISH: begin
        // hold until the result register is free
        if (!status.out_busy) begin
          cmd        = rps_pkg::CMD_FINISH;
          state_next = rps_pkg::ST_IDLE;
        end
      end
      default: state_next = rps_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ----- hdl/rps_dp.sv -----
// Datapath: configuration registers, pattern vectors, step counters and result register.
// Depends on rps_pkg; commanded by rps_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module rps_dp (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire rps_pkg::cmd_t                    cmd,
  output rps_pkg::status_t                      status,
  input  wire logic                             cfg_we,
  input  wire logic [rps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rps_pkg::CFG_DAT_W-1:0]    cfg_data,
  input  wire logic                             in_clock_edge,
  input  wire logic                             in_reset_edge,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_gate,
  output logic                                  out_accent,
  output logic                                  out_eoc,
  output logic [rps_pkg::CNT_W-1:0]             out_step,
  output logic [rps_pkg::WORD_W-1:0]            out_word
);
  localparam int IW = rps_pkg::IDX_W;
  localparam int CW = rps_pkg::CNT_W;
  localparam int MS = rps_pkg::MAX_STEPS;

  // configuration
  logic [CW-1:0] len_reg, hits_reg, acc_reg;
  logic [IW-1:0] pad_reg, rot_reg, ash_reg;
  logic          style, back, pending;

  // effective settings
  logic [CW-1:0] l, f, a, size, room;
  logic [IW-1:0] p, r, s;

  always_comb begin
    l    = (len_reg == '0) ? CW'(1) : ((len_reg > CW'(MS)) ? CW'(MS) : len_reg);
    room = CW'(MS) - l;
    p    = ({1'b0, pad_reg} > room) ? room[IW-1:0] : pad_reg;
    size = l + {1'b0, p};
    r    = ({1'b0, rot_reg} > size - CW'(1)) ? IW'(size - CW'(1)) : rot_reg;
    f    = (hits_reg == '0) ? CW'(1) : ((hits_reg > l) ? l : hits_reg);
    a    = (acc_reg > f) ? f : acc_reg;
    s    = (a == '0) ? '0 : (({1'b0, ash_reg} > f - CW'(1)) ? IW'(f - CW'(1)) : ash_reg);
  end

  // pattern storage
  logic [MS-1:0] seq, src, hit, acc;
  // builder counters
  logic [CW-1:0] i;
  logic [CW:0]   rem;
  logic [IW-1:0] q, fa, fb, rp, accm;
  // tick state
  logic          tclk, trst, fc, eoc;
  logic [CW-1:0] pos, m, k;
  logic [rps_pkg::WORD_W-1:0] w, last;

  // shared placement unit for the hit and accent-source phases
  logic          src_phase;
  logic [CW-1:0] den, stp;
  logic [CW-1:0] fsum, fb_next;
  logic          gen_done;
  always_comb begin
    src_phase = (cmd == rps_pkg::CMD_SRC);
    den       = src_phase ? a : f;
    stp       = src_phase ? f : l;
    fsum      = {1'b0, fa} + {1'b0, fb};
    fb_next   = (fsum >= stp) ? fsum - stp : fsum;
    gen_done  = (i == den);
  end

  // tick update
  logic [CW-1:0] pos0, pos_n, inc;
  logic          fc0, wrapped;
  always_comb begin
    pos0    = trst ? (back ? '0 : size) : pos;
    fc0     = trst | fc;
    inc     = pos0 + CW'(1);
    wrapped = 1'b0;
    pos_n   = pos0;
    if (tclk) begin
      if (!back) begin
        if (inc >= size) begin
          pos_n = '0; wrapped = 1'b1;
        end else begin
          pos_n = inc;
        end
      end else if (pos0 == '0 || pos0 > size) begin
        pos_n = size - CW'(1); wrapped = 1'b1;
      end else begin
        pos_n = pos0 - CW'(1);
      end
    end
  end

  logic [IW-1:0] rd_idx, m_inc;
  logic          accent_place;
  always_comb begin
    rd_idx       = IW'(m) + p;
    m_inc        = IW'(m) + IW'(1);
    accent_place = (a != '0) && seq[i[IW-1:0]];
  end

  always_comb begin
    status.pending    = pending;
    status.out_busy   = out_valid & ~out_ready;
    status.tick_clk   = tclk;
    status.seq_done   = gen_done;
    status.src_done   = gen_done;
    status.place_done = (i == l);
    status.mod_done   = (m < l);
    status.shift_done = (k == l);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      len_reg <= CW'(16); pad_reg <= '0; rot_reg <= '0; hits_reg <= CW'(4);
      acc_reg <= '0; ash_reg <= '0; style <= 1'b0; back <= 1'b0;
      pending <= 1'b1; pos <= '0; fc <= 1'b1; last <= '0; out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        pending <= 1'b1;
        case (cfg_index)
          rps_pkg::REG_LENGTH: len_reg  <= cfg_data;
          rps_pkg::REG_PAD:    pad_reg  <= cfg_data[IW-1:0];
          rps_pkg::REG_ROTATE: rot_reg  <= cfg_data[IW-1:0];
          rps_pkg::REG_HITS:   hits_reg <= cfg_data;
          rps_pkg::REG_ACCENT: acc_reg  <= cfg_data;
          rps_pkg::REG_ASHIFT: ash_reg  <= cfg_data[IW-1:0];
          rps_pkg::REG_STYLE:  style    <= cfg_data[0];
          rps_pkg::REG_BACK:   back     <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd == rps_pkg::CMD_PLACE && i == l) pending <= 1'b0;
      if (cmd == rps_pkg::CMD_STEP) begin
        pos <= pos_n;
        fc  <= (tclk && pos_n != '0) ? 1'b0 : fc0;
      end
      if (cmd == rps_pkg::CMD_FINISH) begin
        out_valid <= 1'b1;
        if (tclk) last <= w;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload and work registers
  always_ff @(posedge clk) begin
    case (cmd)
      rps_pkg::CMD_LOAD: begin
        tclk <= in_clock_edge;
        trst <= in_reset_edge;
      end
      rps_pkg::CMD_CLEAR: begin
        seq <= '0; src <= '0; hit <= '0; acc <= '0;
        i <= '0; q <= '0; rem <= '0; fa <= '0;
        fb <= (l == CW'(1)) ? '0 : IW'(1);
      end
      rps_pkg::CMD_SRC_INIT: begin
        i <= '0; q <= '0; rem <= '0; fa <= '0;
        fb <= (f == CW'(1)) ? '0 : IW'(1);
      end
      rps_pkg::CMD_SEQ, rps_pkg::CMD_SRC: begin
        if (!gen_done) begin
          if (style) begin
            if (src_phase) src[fa] <= 1'b1;
            else           seq[fa] <= 1'b1;
            fa <= fb;
            fb <= fb_next[IW-1:0];
            i  <= i + CW'(1);
          end else if (rem >= {1'b0, den}) begin
            // one subtract per cycle until the quotient is known
            rem <= rem - {1'b0, den};
            q   <= q + IW'(1);
          end else begin
            if (src_phase) src[q] <= 1'b1;
            else           seq[q] <= 1'b1;
            rem <= rem + {1'b0, stp};
            i   <= i + CW'(1);
          end
        end
      end
      rps_pkg::CMD_PLACE_INIT: begin
        i    <= '0;
        rp   <= r;
        accm <= (s == '0) ? '0 : IW'(f - {1'b0, s});
      end
      rps_pkg::CMD_PLACE: begin
        if (i != l) begin
          hit[rp] <= seq[i[IW-1:0]];
          acc[rp] <= accent_place ? src[accm] : 1'b0;
          if (accent_place) accm <= ({1'b0, accm} + CW'(1) == f) ? '0 : accm + IW'(1);
          rp <= ({1'b0, rp} + CW'(1) == size) ? '0 : rp + IW'(1);
          i  <= i + CW'(1);
        end
      end
      rps_pkg::CMD_STEP: begin
        eoc <= tclk & wrapped & ~fc0;
        m   <= pos_n;
        k   <= '0;
        w   <= '0;
      end
      rps_pkg::CMD_MOD: begin
        if (m >= l) m <= m - l;
      end
      rps_pkg::CMD_SHIFT: begin
        if (k != l) begin
          w <= {w[rps_pkg::WORD_W-2:1], w[0] | hit[rd_idx], 1'b0};
          m <= ({1'b0, m_inc} == l) ? '0 : CW'(m_inc);
          k <= k + CW'(1);
        end
      end
      rps_pkg::CMD_FINISH: begin
        out_gate   <= tclk & hit[pos[IW-1:0]];
        out_accent <= tclk & (a != '0) & acc[pos[IW-1:0]];
        out_eoc    <= eoc;
        out_step   <= pos;
        out_word   <= tclk ? w : last;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ----- hdl/rhythm_pattern_sequencer.sv -----
// Rhythm pattern sequencer top level: ties the controller to the datapath and the channels.
// Depends on rps_pkg, rps_if (rps_in_if, rps_out_if, rps_cfg_if), rps_ctrl and rps_dp.
// A tick without a clock edge goes straight from the step state to the finish state; a
// clocked tick also runs the serial modulo of the new position by the pattern length and
// the one-bit-per-cycle shift word build. After a register write the next tick first
// rebuilds the pattern. One tick at a time; a new tick is taken while a result waits, and
// the last step of the tick holds until that result is taken. Reset (rst, synchronous)
// restores register defaults and marks the pattern for rebuild.
`timescale 1ns / 1ps
`default_nettype none
module rhythm_pattern_sequencer (
  input  wire logic  clk,
  input  wire logic  rst,
  rps_in_if.sink     in_ch,
  rps_out_if.source  out_ch,
  rps_cfg_if.sink    cfg
);
  rps_pkg::cmd_t    cmd;
  rps_pkg::status_t status;
  logic             in_ready;

  // the user must write registers only while the block is idle; not enforced here, so always take the write
  assign cfg.ready   = 1'b1;
  assign in_ch.ready = in_ready;

  rps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath holds the pattern, the step position and the result register
  rps_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg.valid),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .in_clock_edge (in_ch.clock_edge),
    .in_reset_edge (in_ch.reset_edge),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_gate      (out_ch.gate_hit),
    .out_accent    (out_ch.accent_hit),
    .out_eoc       (out_ch.end_of_cycle),
    .out_step      (out_ch.step_index),
    .out_word      (out_ch.shift_word)
  );
endmodule
`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking bench for the rhythm pattern sequencer: register setups, directed and random ticks.
// Depends on rps_pkg, the rps_if channel interfaces and the rhythm_pattern_sequencer RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  // Stop the run when no transaction of any channel moves for this many cycles.
  localparam int STALL_LIMIT = 5000;
  // Settle time after the last result: a clocked tick plus a full rebuild.
  localparam int SETTLE_CYCLES = 200;

  typedef struct packed {
    logic                       gate;
    logic                       accent;
    logic                       eoc;
    logic [rps_pkg::CNT_W-1:0]  index;
    logic [rps_pkg::WORD_W-1:0] word;
  } step_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rps_in_if  in_ch ();
  rps_out_if out_ch ();
  rps_cfg_if cfg_ch ();

  rhythm_pattern_sequencer u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg_ch)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow copy of the sequencer: registers, pattern and step state
  // ---------------------------------------------------------------------------
  logic [rps_pkg::CFG_DAT_W-1:0] reg_val [8];
  bit                            pat_hit [rps_pkg::MAX_STEPS];
  bit                            pat_acc [rps_pkg::MAX_STEPS];
  bit                            acc_src [rps_pkg::MAX_STEPS];
  int                            pos;
  bit                            first_lap;
  bit                            stale_pattern;
  logic [rps_pkg::WORD_W-1:0]    held_word;

  step_result_t expected_steps [$];

  int errors      = 0;
  int ticks_sent  = 0;
  int steps_seen  = 0;
  int setups_done = 0;
  int in_idle_pct  = 30;
  int out_idle_pct = 30;

  function automatic int eff_len();
    int v = reg_val[rps_pkg::REG_LENGTH];
    if (v < 1) v = 1;
    if (v > rps_pkg::MAX_STEPS) v = rps_pkg::MAX_STEPS;
    return v;
  endfunction

  function automatic int eff_pad();
    int room = rps_pkg::MAX_STEPS - eff_len();
    return (reg_val[rps_pkg::REG_PAD] > room) ? room : int'(reg_val[rps_pkg::REG_PAD]);
  endfunction

  function automatic int eff_fill();
    int v = reg_val[rps_pkg::REG_HITS];
    int l = eff_len();
    if (v < 1) v = 1;
    if (v > l) v = l;
    return v;
  endfunction

  function automatic int eff_accents();
    int f = eff_fill();
    return (reg_val[rps_pkg::REG_ACCENT] > f) ? f : int'(reg_val[rps_pkg::REG_ACCENT]);
  endfunction

  function automatic longint unsigned fib_at(int n);
    longint unsigned a = 0, b = 1, t;
    for (int i = 0; i < n; i++) begin
      t = a + b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // Lay out hits and accents, then rotate them into place within length plus padding.
  function automatic void rebuild_pattern();
    int l, p, f, a, size, r, s, acc, idx;
    bit seq [rps_pkg::MAX_STEPS];
    l = eff_len();
    p = eff_pad();
    f = eff_fill();
    a = eff_accents();
    size = l + p;
    r = (reg_val[rps_pkg::REG_ROTATE] > size - 1) ? size - 1
                                                   : int'(reg_val[rps_pkg::REG_ROTATE]);
    s = 0;
    if (a != 0)
      s = (reg_val[rps_pkg::REG_ASHIFT] > f - 1) ? f - 1 : int'(reg_val[rps_pkg::REG_ASHIFT]);
    for (int i = 0; i < rps_pkg::MAX_STEPS; i++) begin
      seq[i] = 0;
      acc_src[i] = 0;
      pat_hit[i] = 0;
      pat_acc[i] = 0;
    end
    for (int i = 0; i < f; i++) begin
      idx = reg_val[rps_pkg::REG_STYLE][0] ? int'(fib_at(i) % l) : (l * i) / f;
      seq[idx % rps_pkg::MAX_STEPS] = 1;
    end
    for (int i = 0; i < a; i++) begin
      idx = reg_val[rps_pkg::REG_STYLE][0] ? int'(fib_at(i) % f) : (f * i) / a;
      acc_src[idx % rps_pkg::MAX_STEPS] = 1;
    end
    acc = f - s;
    for (int i = 0; i < l; i++) begin
      idx = ((i + r) % size) % rps_pkg::MAX_STEPS;
      pat_hit[idx] = seq[i];
      pat_acc[idx] = 0;
      if (a != 0 && seq[i]) begin
        pat_acc[idx] = acc_src[(acc % f) % rps_pkg::MAX_STEPS];
        acc++;
      end
    end
    stale_pattern = 0;
  endfunction

  // Work out the result of one tick and advance the shadow state.
  function automatic step_result_t predict_step(bit clock_e, bit reset_e);
    step_result_t res;
    int l, p, size, idx;
    bit wrapped;
    longint unsigned w;
    res = '0;
    if (stale_pattern) rebuild_pattern();
    l = eff_len();
    p = eff_pad();
    size = l + p;
    if (reset_e) begin
      pos = reg_val[rps_pkg::REG_BACK][0] ? 0 : size;
      first_lap = 1;
    end
    if (clock_e) begin
      wrapped = 0;
      w = 0;
      if (!reg_val[rps_pkg::REG_BACK][0]) begin
        pos++;
        if (pos >= size) begin
          pos = 0;
          wrapped = 1;
        end
      end else if (pos == 0 || pos > size) begin
        pos = size - 1;
        wrapped = 1;
      end else begin
        pos--;
      end
      if (wrapped && !first_lap) res.eoc = 1'b1;
      if (first_lap && pos != 0) first_lap = 0;
      for (int k = 0; k < l; k++) begin
        idx = (((pos + k) % l) + p) % rps_pkg::MAX_STEPS;
        w = (w | longint'(pat_hit[idx])) << 1;
      end
      held_word = w[rps_pkg::WORD_W-1:0];
      res.gate = pat_hit[pos % rps_pkg::MAX_STEPS];
      if (eff_accents() != 0) res.accent = pat_acc[pos % rps_pkg::MAX_STEPS];
    end
    res.index = pos[rps_pkg::CNT_W-1:0];
    res.word  = held_word;
    return res;
  endfunction

  function automatic void shadow_reset();
    reg_val[rps_pkg::REG_LENGTH] = 6'd16;
    reg_val[rps_pkg::REG_PAD]    = '0;
    reg_val[rps_pkg::REG_ROTATE] = '0;
    reg_val[rps_pkg::REG_HITS]   = 6'd4;
    reg_val[rps_pkg::REG_ACCENT] = '0;
    reg_val[rps_pkg::REG_ASHIFT] = '0;
    reg_val[rps_pkg::REG_STYLE]  = '0;
    reg_val[rps_pkg::REG_BACK]   = '0;
    for (int i = 0; i < rps_pkg::MAX_STEPS; i++) begin
      pat_hit[i] = 0;
      pat_acc[i] = 0;
      acc_src[i] = 0;
    end
    pos = 0;
    first_lap = 1;
    stale_pattern = 1;
    held_word = '0;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------

  // Offer one tick; hold valid high afterwards so back-to-back ticks need no gap.
  task automatic send_tick(bit clock_e, bit reset_e);
    if ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_ch.valid      <= 1'b1;
    in_ch.clock_edge <= clock_e;
    in_ch.reset_edge <= reset_e;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_steps.push_back(predict_step(clock_e, reset_e));
    ticks_sent++;
  endtask

  // Drop valid and let the edge pass before anything else drives the channel.
  task automatic stop_ticks();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_results();
    stop_ticks();
    while (expected_steps.size() != 0) @(posedge clk);
  endtask

  // Registers are written only once the block has handed back every result.
  task automatic write_reg(logic [rps_pkg::CFG_IDX_W-1:0] idx,
                           logic [rps_pkg::CFG_DAT_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      rps_pkg::REG_PAD, rps_pkg::REG_ROTATE, rps_pkg::REG_ASHIFT:
        reg_val[idx] = data & 6'h1F;
      rps_pkg::REG_STYLE, rps_pkg::REG_BACK:
        reg_val[idx] = data & 6'h01;
      default:
        reg_val[idx] = data;
    endcase
    stale_pattern = 1;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic setup(int len, int pad, int rot, int hits, int acc, int ash, int sty, int back);
    wait_results();
    write_reg(rps_pkg::REG_LENGTH, len[rps_pkg::CFG_DAT_W-1:0]);
    write_reg(rps_pkg::REG_PAD,    pad[rps_pkg::CFG_DAT_W-1:0]);
    write_reg(rps_pkg::REG_ROTATE, rot[rps_pkg::CFG_DAT_W-1:0]);
    write_reg(rps_pkg::REG_HITS,   hits[rps_pkg::CFG_DAT_W-1:0]);
    write_reg(rps_pkg::REG_ACCENT, acc[rps_pkg::CFG_DAT_W-1:0]);
    write_reg(rps_pkg::REG_ASHIFT, ash[rps_pkg::CFG_DAT_W-1:0]);
    write_reg(rps_pkg::REG_STYLE,  sty[rps_pkg::CFG_DAT_W-1:0]);
    write_reg(rps_pkg::REG_BACK,   back[rps_pkg::CFG_DAT_W-1:0]);
    setups_done++;
  endtask

  // Random tick: mostly clocked, reset edges now and then.
  task automatic random_tick();
    send_tick($urandom_range(99) < 80, $urandom_range(99) < 8);
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      steps_seen++;
      if (expected_steps.size() == 0) begin
        report_mismatch("result with no tick outstanding");
      end else begin
        step_result_t e;
        e = expected_steps.pop_front();
        if (out_ch.gate_hit !== e.gate)
          report_mismatch($sformatf("gate_hit %b, want %b", out_ch.gate_hit, e.gate));
        if (out_ch.accent_hit !== e.accent)
          report_mismatch($sformatf("accent_hit %b, want %b", out_ch.accent_hit, e.accent));
        if (out_ch.end_of_cycle !== e.eoc)
          report_mismatch($sformatf("end_of_cycle %b, want %b", out_ch.end_of_cycle, e.eoc));
        if (out_ch.step_index !== e.index)
          report_mismatch($sformatf("step_index %0d, want %0d", out_ch.step_index, e.index));
        if (out_ch.shift_word !== e.word)
          report_mismatch($sformatf("shift_word %h, want %h", out_ch.shift_word, e.word));
      end
    end
  end

  // Random back-pressure on the result side.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // Watchdog: cycles in a row with no transaction on any channel.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction in %0d cycles", STALL_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: each clock/reset edge combination, first lap without end_of_cycle.
  task automatic test_defaults();
    send_tick(0, 0);
    send_tick(1, 0);
    send_tick(0, 1);
    send_tick(1, 1);
    repeat (18) send_tick(1, 0);
  endtask

  // Register extremes and clamping, both styles, both directions.
  task automatic test_extremes();
    setup(0, 31, 31, 0, 63, 31, 0, 0);     // length and hits below range, pad, rotate, accents and shift at top
    repeat (3) send_tick(1, 0);
    setup(63, 31, 31, 63, 63, 31, 1, 1);   // length above range, fibonacci, backward
    send_tick(1, 1);
    repeat (3) send_tick(1, 0);
    setup(32, 0, 0, 32, 32, 0, 1, 0);      // full-length pattern, hits and accents at 32, fibonacci
    repeat (3) send_tick(1, 0);
    setup(1, 0, 0, 1, 0, 0, 0, 1);         // single step backward
    send_tick(1, 1);
    send_tick(0, 0);
    send_tick(1, 0);
    setup(5, 3, 7, 3, 2, 1, 0, 1);         // padding with backward wrap
    repeat (10) send_tick(1, 0);
  endtask

  // Random register settings, each followed by a burst of random ticks.
  task automatic test_random();
    int n;
    for (int ph = 0; ph < 20; ph++) begin
      if ($urandom_range(3) == 0)
        setup($urandom_range(1, 8), $urandom_range(31), $urandom_range(31),
              $urandom_range(63), $urandom_range(63), $urandom_range(31),
              $urandom_range(1), $urandom_range(1));
      else
        setup($urandom_range(63), $urandom_range(31), $urandom_range(31),
              $urandom_range(63), $urandom_range(63), $urandom_range(31),
              $urandom_range(1), $urandom_range(1));
      // Run one phase at full rate on both sides.
      if (ph == 10) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct = 30;
        out_idle_pct = 30;
      end
      n = 45;
      for (int i = 0; i < n; i++) begin
        // Hold off the sender until the pipe is empty, mid-burst.
        if (ph == 5 && i == 20) wait_results();
        random_tick();
      end
    end
    in_idle_pct = 30;
    out_idle_pct = 30;
  endtask

  initial begin
    shadow_reset();
    in_ch.valid      <= 1'b0;
    in_ch.clock_edge <= 1'b0;
    in_ch.reset_edge <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= '0;
    cfg_ch.data      <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_defaults();
    test_extremes();
    test_random();

    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d ticks, %0d results, %0d register setups", ticks_sent, steps_seen,
             setups_done);
    if (errors == 0 && expected_steps.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expected_steps.size());
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- sim.f -----
hdl/rps_pkg.sv
hdl/rps_if.sv
hdl/rps_ctrl.sv
hdl/rps_dp.sv
hdl/rhythm_pattern_sequencer.sv
sim/tb.sv
